// File: rtl/core/i2f_pkg.sv
// shared types and constants for the int128 to float converter
package i2f_pkg;
  localparam int unsigned MagW = 128;
  localparam int unsigned PosW = 7;

  // payload of the input channel
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] value_low;
    logic [63:0] value_high;
  } in_item_t;

  // payload of the output channel
  typedef struct packed {
    logic [63:0] result_bits;
  } out_item_t;
endpackage

// File: rtl/core/i2f_stream_if.sv
// valid/ready channel interfaces for the converter
interface i2f_in_if;
  import i2f_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2f_out_if;
  import i2f_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/int128_to_float_convert.sv
// int128 to binary64/binary32 converter, four-stage pipeline
// Usage: items arrive on in_if (kind, value_low, value_high) and results
// leave on out_if (result_bits). A transfer happens when valid and ready
// are both high. The pipeline has four register stages:
//   stage 1: sign strip and negate to a 128-bit magnitude
//   stage 2: leading-one position by a two-level search
//   stage 3: normalizing shift so the leading one sits at bit 127
//   stage 4: round to nearest-even, exponent and packing
// A result passes the stage 1 to stage 4 registers before out_if.valid, and one item
// is taken per cycle while out_if.ready stays high, limited by no unit in the datapath.
// When the receiver stalls, stage 4 holds, and an earlier stage holds only once
// all after it are full: in_if.ready falls only once every stage holds a valid
// item; nothing is lost or repeated, and stages advance into empty slots.
// Reset clears all valid bits; payload registers are not reset.
// Zero gives +0, and a binary32 result rounding to 2^128 is infinity.
module int128_to_float_convert
  import i2f_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  i2f_in_if.sink    in_if,
  i2f_out_if.source out_if
);

  // stage valid bits and advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  assign en4 = !v4_q || out_if.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_if.ready = en1;

  // stage 1: magnitude
  logic [MagW-1:0] mag1_d, mag1_q;
  logic            neg1_d, neg1_q, sgl1_q;
  always_comb begin
    neg1_d = in_if.data.kind[1] && in_if.data.value_high[63];
    mag1_d = {in_if.data.value_high, in_if.data.value_low};
    if (neg1_d) mag1_d = ~mag1_d + MagW'(1);
  end

  // stage 2: leading-one search, highest nonzero 16-bit group then the bit within it
  logic [MagW-1:0] mag2_q;
  logic            neg2_q, sgl2_q, nz2_q;
  logic [PosW-1:0] pos2_d, pos2_q;
  always_comb begin
    logic [3:0] grp;
    logic [3:0] sub;
    grp = '0;
    sub = '0;
    for (int g = 0; g < 8; g++) begin
      if (mag1_q[g*16 +: 16] != 16'd0) grp = 4'(g);
    end
    for (int b = 0; b < 16; b++) begin
      if (mag1_q[grp[2:0]*16 + b]) sub = 4'(b);
    end
    pos2_d = {grp[2:0], sub};
  end

  // stage 3: normalize, leading one at bit 127
  logic [MagW-1:0] nrm3_d, nrm3_q;
  logic [PosW-1:0] pos3_q;
  logic            neg3_q, sgl3_q, nz3_q;
  assign nrm3_d = mag2_q << (PosW'(MagW - 1) - pos2_q);

  // stage 4: round and pack
  logic [63:0] res4_d, res4_q;
  always_comb begin
    logic [53:0] sig;
    logic [24:0] sig_s;
    logic        rb, st;
    logic [10:0] ed;
    logic [8:0]  es;
    logic [PosW:0] p;
    res4_d = '0;
    sig = '0;
    sig_s = '0;
    rb = 1'b0;
    st = 1'b0;
    ed = '0;
    es = '0;
    p = {1'b0, pos3_q};
    if (!sgl3_q) begin
      rb = nrm3_q[74];
      st = |nrm3_q[73:0];
      sig = {1'b0, nrm3_q[127:75]};
      if (rb && (st || sig[0])) sig = sig + 54'd1;
      if (sig[53]) p = p + 8'd1;
      ed = 11'(p) + 11'd1023;
      res4_d = {neg3_q, ed, sig[53] ? sig[52:1] : sig[51:0]};
    end else begin
      rb = nrm3_q[103];
      st = |nrm3_q[102:0];
      sig_s = {1'b0, nrm3_q[127:104]};
      if (rb && (st || sig_s[0])) sig_s = sig_s + 25'd1;
      if (sig_s[24]) p = p + 8'd1;
      es = 9'(p) + 9'd127;
      if (es >= 9'd255) res4_d = {32'd0, neg3_q, 8'hFF, 23'd0};
      else res4_d = {32'd0, neg3_q, es[7:0], sig_s[24] ? sig_s[23:1] : sig_s[22:0]};
    end
    if (!nz3_q) res4_d = '0;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_if.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) begin
      mag1_q <= mag1_d;
      neg1_q <= neg1_d;
      sgl1_q <= in_if.data.kind[0];
    end
    if (en2) begin
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      sgl2_q <= sgl1_q;
      nz2_q  <= mag1_q != '0;
      pos2_q <= pos2_d;
    end
    if (en3) begin
      nrm3_q <= nrm3_d;
      pos3_q <= pos2_q;
      neg3_q <= neg2_q;
      sgl3_q <= sgl2_q;
      nz3_q  <= nz2_q;
    end
    if (en4) res4_q <= res4_d;
  end

  assign out_if.valid = v4_q;
  assign out_if.data.result_bits = res4_q;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !out_if.ready |=> v4_q && $stable(res4_q))
    else $error("stalled result changed");
  // ready drops only when the pipe is full
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> v1_q && v2_q && v3_q && v4_q)
    else $error("ready low with a bubble");
  // single results keep upper bits zero
  a_sgl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en4 && v3_q && sgl3_q |=> res4_q[63:32] == 32'd0)
    else $error("single result upper bits set");
endmodule

// File: bench/testbench.sv
// testbench for the int128 to float converter: directed and random transfers
`timescale 1ns / 1ps

module testbench;
  import i2f_pkg::*;

  localparam int unsigned KindUDouble = 0;
  localparam int unsigned KindUSingle = 1;
  localparam int unsigned KindSDouble = 2;
  localparam int unsigned KindSSingle = 3;
  localparam int unsigned IdleLimit = 5000;

  logic clk_i;
  logic rst_ni;
  i2f_in_if  in_if ();
  i2f_out_if out_if ();

  int128_to_float_convert i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  logic [63:0] expected_bits_q[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          hold_off;
  bit          done;

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // rounded conversion of a 128-bit integer, signed or unsigned by kind
  function automatic logic [63:0] float_of_int(logic [1:0] kind, logic [127:0] val);
    logic         single;
    logic         neg;
    logic [127:0] mag;
    int           lead;
    int           mbits;
    int           bias;
    int           shamt;
    logic [63:0]  sig;
    logic         rbit;
    logic         sticky;
    logic [63:0]  expo;
    logic [63:0]  res;
    single = kind[0];
    neg = kind[1] && val[127];
    mag = neg ? (~val + 128'd1) : val;
    if (mag == '0) return '0;
    mbits = single ? 24 : 53;
    bias = single ? 127 : 1023;
    lead = 0;
    for (int k = 0; k < 128; k++) if (mag[k]) lead = k;
    if (lead < mbits) begin
      sig = mag[63:0] << (mbits - 1 - lead);
    end else begin
      shamt = lead - (mbits - 1);
      rbit = mag[shamt-1];
      sticky = (shamt > 1) ? ((mag & ((128'd1 << (shamt - 1)) - 128'd1)) != '0) : 1'b0;
      sig = 64'(mag >> shamt);
      if (rbit && (sticky || sig[0])) sig = sig + 64'd1;
      if (sig == (64'd1 << mbits)) begin
        sig = sig >> 1;
        lead = lead + 1;
      end
    end
    expo = 64'(lead + bias);
    if (single) begin
      res = (expo >= 64'd255) ? 64'h7F80_0000 : ((expo << 23) | (sig & 64'h7F_FFFF));
      if (neg) res[31] = 1'b1;
    end else begin
      res = (expo << 52) | (sig & 64'h000F_FFFF_FFFF_FFFF);
      if (neg) res[63] = 1'b1;
    end
    return res;
  endfunction

  // send one item, with random gaps between bursts
  int unsigned burst_left;
  task automatic send_value(logic [1:0] kind, logic [127:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) * ($urandom_range(0, 2) == 0);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data.kind <= kind;
    in_if.data.value_low <= val[63:0];
    in_if.data.value_high <= val[127:64];
    do @(posedge clk_i); while (!in_if.ready);
    expected_bits_q.push_back(float_of_int(kind, val));
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  // random value with a random leading position and patterned low bits, sometimes negated
  function automatic logic [127:0] rand_value();
    logic [127:0] v;
    int unsigned  width;
    v = {$urandom, $urandom, $urandom, $urandom};
    width = $urandom_range(1, 128);
    if (width < 128) v = v & ((128'd1 << width) - 128'd1);
    case ($urandom_range(0, 5))
      0: v[40:0] = '0;
      1: v[40:0] = '1;
      2: v = v & ~((128'd1 << $urandom_range(0, 100)) - 128'd1);
      3: v = {v[127:64], 64'd0};
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) v = ~v + 128'd1;
    return v;
  endfunction

  task automatic test_extremes();
    logic [127:0] vals[12];
    vals = '{128'd0, 128'd1, {128{1'b1}}, {1'b1, 127'd0}, {1'b0, {127{1'b1}}},
             128'h0000_0000_0000_0000_0020_0000_0000_0001,
             128'h0000_0000_0000_0000_0030_0000_0000_0000,
             {24'hFFFFFF, 1'b1, 103'd0}, {24'hFFFFFF, 1'b0, 103'd0},
             128'hFFFF_FFFF_FFFF_FFFF_0000_0000_0000_0000,
             128'h0000_0000_0000_0000_FFFF_FFFF_FFFF_FFFF, 128'd16777217};
    foreach (vals[i]) begin
      send_value(2'(KindUDouble), vals[i]);
      send_value(2'(KindUSingle), vals[i]);
    end
  endtask

  task automatic test_signed();
    send_value(2'(KindSDouble), {1'b1, 127'd0});
    send_value(2'(KindSSingle), {1'b1, 127'd0});
    send_value(2'(KindSDouble), {128{1'b1}});
    send_value(2'(KindSSingle), 128'd0);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_value(2'($urandom_range(KindUDouble, KindSSingle)), rand_value());
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    test_random(40);
  endtask

  // receiver stall pattern, with a long hold-off when asked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= hold_off ? 1'b0 : ($urandom_range(0, 9) < 7 || done);
    end
  end

  // the long hold-off is released by this process
  initial begin
    forever begin
      wait (hold_off);
      repeat (60) @(posedge clk_i);
      hold_off = 1'b0;
    end
  end

  // compare each result transfer
  always @(posedge clk_i) begin
    logic [63:0] exp_bits;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_bits_q.size() == 0) begin
        $error("result_bits: unexpected result %h", out_if.data.result_bits);
        error_count++;
      end else begin
        exp_bits = expected_bits_q.pop_front();
        if (out_if.data.result_bits !== exp_bits) begin
          $error("result_bits: expected %h actual %h", exp_bits, out_if.data.result_bits);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || hold_off)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    hold_off = 1'b0;
    done = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_signed();
    test_random(700);
    test_backpressure();
    test_random(700);
    stop_sending();
    done = 1'b1;
    wait (expected_bits_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && expected_bits_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/i2f_pkg.sv
rtl/core/i2f_stream_if.sv
rtl/core/int128_to_float_convert.sv
bench/testbench.sv
